[rtl/psu_pkg.sv]
// Shared types, constants and helper functions of the particle state update block.
`timescale 1ns / 1ps

package psu_pkg;

  localparam int PARTICLES_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;
  localparam int AGE_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int AR_CNT_BITS   = 5;

  localparam logic [AGE_BITS:0] AGE_ONE = {1'b1, {AGE_BITS{1'b0}}};

  // Register reset values.
  localparam logic [30:0] INITIAL_SPEED_RST = 31'd0;
  localparam logic [30:0] FINAL_SPEED_RST   = 31'd0;
  localparam logic [15:0] INITIAL_SIZE_RST  = 16'd256;
  localparam logic [15:0] FINAL_SIZE_RST    = 16'd256;
  localparam logic [23:0] LIFESPAN_RST      = 24'd327680;
  localparam logic [31:0] INITIAL_RGBA_RST  = 32'hFFFF_FFFF;
  localparam logic [31:0] FINAL_RGBA_RST    = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INITIAL_SPEED = 3'd0,
    REG_FINAL_SPEED   = 3'd1,
    REG_INITIAL_SIZE  = 3'd2,
    REG_FINAL_SIZE    = 3'd3,
    REG_LIFESPAN      = 3'd4,
    REG_INITIAL_RGBA  = 3'd5,
    REG_FINAL_RGBA    = 3'd6
  } psu_reg_e;

  typedef enum logic {
    CMD_SPAWN = 1'b0,
    CMD_STEP  = 1'b1
  } psu_cmd_e;

  typedef enum logic {
    VSEL_ACCEL = 1'b0,
    VSEL_VEL   = 1'b1
  } psu_vsel_e;

  typedef enum logic {
    AR_DIV  = 1'b0,
    AR_SQRT = 1'b1
  } psu_arop_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_AGE,
    S_AGE_WAIT,
    S_BL_SPD,
    S_BL_SIZE,
    S_BL_COL,
    S_AMAG,
    S_SQ_MUL,
    S_SQ_ADD,
    S_SQRT,
    S_SQRT_WAIT,
    S_RS_MUL,
    S_RS_DIV,
    S_RS_WAIT,
    S_POS_MUL,
    S_POS_ADD,
    S_DONE
  } psu_state_e;

  typedef struct packed {
    psu_cmd_e           cmd;
    logic [7:0]         particle;
    logic [15:0]        delta_time;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [30:0]        accel_amount;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
  } psu_in_t;

  typedef struct packed {
    logic [7:0]         particle_out;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        size_now;
    logic [31:0]        rgba_now;
    logic signed [31:0] life_left;
  } psu_out_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] life;
  } psu_entry_t;

  typedef struct packed {
    logic        start;
    psu_arop_e   op;
    logic [63:0] num;
    logic [31:0] den;
  } psu_ar_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] result;
  } psu_ar_rsp_t;

  // Magnitude of a signed 32-bit value; the most negative value becomes 2^31.
  function automatic logic [32:0] psu_abs(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = {v[31], v};
    return e[32] ? 33'(-e) : 33'(e);
  endfunction

  // Clamp a wide signed value into the signed 32-bit range.
  function automatic logic signed [31:0] psu_sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (!v[65] && (|v[64:31])) begin
      r = 32'sh7FFF_FFFF;
    end else if (v[65] && !(&v[64:31])) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/psu_if.sv]
// Handshake channel interfaces for items, results and register writes.
`timescale 1ns / 1ps

interface psu_in_if;
  import psu_pkg::*;
  logic    valid;
  logic    ready;
  psu_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psu_out_if;
  import psu_pkg::*;
  logic     valid;
  logic     ready;
  psu_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psu_cfg_if;
  import psu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [31:0]             data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/particle_state_update.sv]
// Top level of the particle state update block: particle table and step sequencer.
`timescale 1ns / 1ps

// Channel   Dir  Beat payload                                  Handshake
// in_i      in   cmd, particle, delta_time, vec, accel, start   valid/ready
// out_o     out  particle_out, pos, size_now, rgba_now, life    valid/ready
// cfg_i     in   register index, write data                     valid/ready (ready always high)
//
// A spawn beat goes straight to the done state, which loads its result into the
// output register once that register is free. A step beat takes one table read, the
// age divide unless the age fraction saturates, six blend products and the
// acceleration product, two vector passes each made of three squares, a square root
// and, for a nonzero root, three divides, and three position products. The bit-serial
// divide and root unit is used up to nine times per step. One item is in work at a
// time; the next is taken once the result sits in the output register, which may
// wait on out_o.ready.
// Reset clears control state and the configuration registers; the particle table holds no reset value.
module particle_state_update #(
  parameter int PARTICLES = psu_pkg::PARTICLES_DEF,
  parameter int FRAC_BITS = psu_pkg::FRAC_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  psu_in_if.sink     in_i,
  psu_out_if.source  out_o,
  psu_cfg_if.sink    cfg_i
);
  import psu_pkg::*;

  localparam int ADDR_W = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

  // Configuration registers.
  logic [30:0] initial_speed_q, final_speed_q;
  logic [15:0] initial_size_q, final_size_q;
  logic [23:0] lifespan_q;
  logic [31:0] initial_rgba_q, final_rgba_q;

  // Sequencer control.
  psu_state_e state_q, state_d;
  psu_vsel_e  vsel_q;
  logic [1:0] comp_q;
  logic [2:0] col_q;
  logic       out_valid_q;

  // Working registers of the item in flight.
  logic [7:0]         p_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [15:0]        dt_q;
  logic [30:0]        accel_q;
  logic signed [31:0] adir_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] life_q;
  logic [AGE_BITS:0]  age_q;
  logic [30:0]        speed_q, amag_q;
  logic [15:0]        size_q;
  logic [31:0]        rgba_q;
  logic [63:0]        acc_q;
  logic [31:0]        len_q;
  logic signed [65:0] prod_q;
  psu_out_t           out_q;

  // Particle table.
  psu_entry_t mem_q [PARTICLES];
  psu_entry_t rd_q;
  psu_entry_t wr_entry;

  psu_ar_req_t ar_req;
  psu_ar_rsp_t ar_rsp;

  logic              in_fire, in_range, fire_done, go_vel_sq;
  logic [ADDR_W-1:0] in_addr;

  logic signed [33:0] elapsed;
  logic               age_special;
  logic [AGE_BITS:0]  age_sp_val;

  logic signed [32:0] mul_a, mul_b;
  logic [31:0]        bl_base;
  logic signed [65:0] bl_sum;
  logic [31:0]        bl_res;
  logic signed [31:0] src_c;
  logic [32:0]        src_abs;
  logic [7:0]         ch_init, ch_final;
  logic [47:0]        amag_sh, pm_sh;
  logic signed [65:0] q_signed, step_signed;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_range    = {24'd0, in_i.data.particle} < 32'(PARTICLES);
  assign in_addr     = ADDR_W'(in_i.data.particle);
  assign fire_done   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_speed_q <= INITIAL_SPEED_RST;
      final_speed_q   <= FINAL_SPEED_RST;
      initial_size_q  <= INITIAL_SIZE_RST;
      final_size_q    <= FINAL_SIZE_RST;
      lifespan_q      <= LIFESPAN_RST;
      initial_rgba_q  <= INITIAL_RGBA_RST;
      final_rgba_q    <= FINAL_RGBA_RST;
    end else if (cfg_i.valid) begin
      unique case (psu_reg_e'(cfg_i.index))
        REG_INITIAL_SPEED: initial_speed_q <= cfg_i.data[30:0];
        REG_FINAL_SPEED:   final_speed_q   <= cfg_i.data[30:0];
        REG_INITIAL_SIZE:  initial_size_q  <= cfg_i.data[15:0];
        REG_FINAL_SIZE:    final_size_q    <= cfg_i.data[15:0];
        REG_LIFESPAN:      lifespan_q      <= cfg_i.data[23:0];
        REG_INITIAL_RGBA:  initial_rgba_q  <= cfg_i.data;
        REG_FINAL_RGBA:    final_rgba_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The age fraction is (lifespan - life) / lifespan; its saturated ends skip the divide.
  always_comb begin
    elapsed     = $signed({10'd0, lifespan_q}) - $signed({{2{life_q[31]}}, life_q});
    age_special = 1'b1;
    age_sp_val  = AGE_ONE;
    if (lifespan_q == '0) begin
      age_sp_val = AGE_ONE;
    end else if (elapsed[33] || (elapsed == '0)) begin
      age_sp_val = '0;
    end else if (elapsed >= $signed({10'd0, lifespan_q})) begin
      age_sp_val = AGE_ONE;
    end else begin
      age_special = 1'b0;
    end
  end

  assign src_c    = (vsel_q == VSEL_ACCEL) ? adir_q[comp_q] : vel_q[comp_q];
  assign src_abs  = psu_abs(src_c);
  assign ch_init  = initial_rgba_q[{col_q[1:0], 3'b000} +: 8];
  assign ch_final = final_rgba_q[{col_q[1:0], 3'b000} +: 8];

  // Blends use a + ((b - a) * t + half) / 2^16, which equals the weighted form exactly.
  always_comb begin
    bl_base = 32'd0;
    if (state_q == S_BL_SIZE) begin
      bl_base = {1'b0, initial_speed_q};
    end else if (col_q == 3'd0) begin
      bl_base = {16'd0, initial_size_q};
    end else begin
      bl_base = {24'd0, initial_rgba_q[{col_q[1:0] - 2'd1, 3'b000} +: 8]};
    end
    bl_sum = $signed({18'd0, bl_base, 16'd0}) + prod_q + 66'sd32768;
    bl_res = bl_sum[47:16];
  end

  // Shared multiplier operands, one product per cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_BL_SPD: begin
        mul_a = $signed({2'b00, final_speed_q}) - $signed({2'b00, initial_speed_q});
        mul_b = $signed({16'd0, age_q});
      end
      S_BL_SIZE: begin
        mul_a = $signed({17'd0, final_size_q}) - $signed({17'd0, initial_size_q});
        mul_b = $signed({16'd0, age_q});
      end
      S_BL_COL: begin
        if (col_q == 3'd4) begin
          mul_a = $signed({2'b00, accel_q});
          mul_b = $signed({17'd0, dt_q});
        end else begin
          mul_a = $signed({25'd0, ch_final}) - $signed({25'd0, ch_init});
          mul_b = $signed({16'd0, age_q});
        end
      end
      S_SQ_MUL: begin
        mul_a = $signed(src_abs);
        mul_b = $signed(src_abs);
      end
      S_RS_MUL: begin
        mul_a = $signed(src_abs);
        mul_b = (vsel_q == VSEL_ACCEL) ? $signed({2'b00, amag_q}) : $signed({2'b00, speed_q});
      end
      S_POS_MUL: begin
        mul_a = $signed(psu_abs(vel_q[comp_q]));
        mul_b = $signed({17'd0, dt_q});
      end
      default: ;
    endcase
  end

  always_comb begin
    ar_req.start = 1'b0;
    ar_req.op    = AR_DIV;
    ar_req.num   = {24'd0, elapsed[23:0], 16'd0};
    ar_req.den   = {8'd0, lifespan_q};
    unique case (state_q)
      S_AGE: ar_req.start = !age_special;
      S_SQRT: begin
        ar_req.start = 1'b1;
        ar_req.op    = AR_SQRT;
        ar_req.num   = acc_q;
      end
      S_RS_DIV: begin
        ar_req.start = 1'b1;
        ar_req.num   = prod_q[63:0];
        ar_req.den   = len_q;
      end
      default: ;
    endcase
  end

  psu_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ar_req),
    .rsp_o  (ar_rsp)
  );

  // After the acceleration pass the velocity pass follows, even when it was skipped.
  assign go_vel_sq = (vsel_q == VSEL_ACCEL) && ar_rsp.done &&
                     (((state_q == S_SQRT_WAIT) && (ar_rsp.result == '0)) ||
                      ((state_q == S_RS_WAIT) && (comp_q == 2'd2)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_range) begin
          state_d = (in_i.data.cmd == CMD_STEP) ? S_LOAD : S_DONE;
        end
      end
      S_LOAD:     state_d = S_AGE;
      S_AGE:      state_d = age_special ? S_BL_SPD : S_AGE_WAIT;
      S_AGE_WAIT: if (ar_rsp.done) state_d = S_BL_SPD;
      S_BL_SPD:   state_d = S_BL_SIZE;
      S_BL_SIZE:  state_d = S_BL_COL;
      S_BL_COL:   if (col_q == 3'd4) state_d = S_AMAG;
      S_AMAG:     state_d = S_SQ_MUL;
      S_SQ_MUL:   state_d = S_SQ_ADD;
      S_SQ_ADD:   state_d = (comp_q == 2'd2) ? S_SQRT : S_SQ_MUL;
      S_SQRT:     state_d = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (ar_rsp.done) begin
          if (ar_rsp.result != '0) begin
            state_d = S_RS_MUL;
          end else begin
            state_d = (vsel_q == VSEL_ACCEL) ? S_SQ_MUL : S_POS_MUL;
          end
        end
      end
      S_RS_MUL:   state_d = S_RS_DIV;
      S_RS_DIV:   state_d = S_RS_WAIT;
      S_RS_WAIT: begin
        if (ar_rsp.done) begin
          if (comp_q != 2'd2) begin
            state_d = S_RS_MUL;
          end else begin
            state_d = (vsel_q == VSEL_ACCEL) ? S_SQ_MUL : S_POS_MUL;
          end
        end
      end
      S_POS_MUL:  state_d = S_POS_ADD;
      S_POS_ADD:  state_d = (comp_q == 2'd2) ? S_DONE : S_POS_MUL;
      S_DONE:     if (fire_done) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vsel_q      <= VSEL_ACCEL;
      comp_q      <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        vsel_q <= VSEL_ACCEL;
        col_q  <= '0;
        comp_q <= '0;
      end else begin
        if (go_vel_sq) begin
          vsel_q <= VSEL_VEL;
        end
        if (state_q == S_BL_COL) begin
          col_q <= col_q + 3'd1;
        end
        if ((state_q == S_SQ_ADD) || (state_q == S_POS_ADD) ||
            ((state_q == S_RS_WAIT) && ar_rsp.done)) begin
          comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
        end
      end
      if (fire_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign amag_sh = prod_q[47:0] >> FRAC_BITS;
  assign pm_sh   = prod_q[47:0] >> FRAC_BITS;
  assign q_signed = src_c[31] ? -$signed({34'd0, ar_rsp.result})
                              : $signed({34'd0, ar_rsp.result});
  // Position steps truncate toward zero, so the shift works on the magnitude.
  assign step_signed = vel_q[comp_q][31] ? -$signed({18'd0, pm_sh}) : $signed({18'd0, pm_sh});

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_fire) begin
      p_q       <= in_i.data.particle;
      addr_q    <= in_addr;
      dt_q      <= in_i.data.delta_time;
      accel_q   <= in_i.data.accel_amount;
      adir_q[0] <= in_i.data.vec_x;
      adir_q[1] <= in_i.data.vec_y;
      adir_q[2] <= in_i.data.vec_z;
      if (in_i.data.cmd == CMD_SPAWN) begin
        pos_q[0] <= in_i.data.start_x;
        pos_q[1] <= in_i.data.start_y;
        pos_q[2] <= in_i.data.start_z;
        vel_q[0] <= in_i.data.vec_x;
        vel_q[1] <= in_i.data.vec_y;
        vel_q[2] <= in_i.data.vec_z;
        life_q   <= $signed({8'd0, lifespan_q});
        size_q   <= initial_size_q;
        rgba_q   <= initial_rgba_q;
      end
    end
    case (state_q)
      S_LOAD: begin
        pos_q[0] <= rd_q.pos_x;
        pos_q[1] <= rd_q.pos_y;
        pos_q[2] <= rd_q.pos_z;
        vel_q[0] <= rd_q.vel_x;
        vel_q[1] <= rd_q.vel_y;
        vel_q[2] <= rd_q.vel_z;
        life_q   <= psu_sat32(66'(rd_q.life) - $signed({50'd0, dt_q}));
      end
      S_AGE:      if (age_special) age_q <= age_sp_val;
      S_AGE_WAIT: if (ar_rsp.done) age_q <= ar_rsp.result[AGE_BITS:0];
      S_BL_SIZE:  speed_q <= bl_res[30:0];
      S_BL_COL: begin
        if (col_q == 3'd0) begin
          size_q <= bl_res[15:0];
        end else begin
          rgba_q[{col_q[1:0] - 2'd1, 3'b000} +: 8] <= bl_res[7:0];
        end
      end
      S_AMAG: begin
        amag_q <= (|amag_sh[47:31]) ? 31'h7FFF_FFFF : amag_sh[30:0];
        acc_q  <= '0;
      end
      S_SQ_ADD:    acc_q <= acc_q + prod_q[63:0];
      S_SQRT_WAIT: begin
        if (ar_rsp.done) begin
          len_q <= ar_rsp.result;
        end
        if (go_vel_sq) begin
          acc_q <= '0;
        end
      end
      S_RS_WAIT: begin
        if (ar_rsp.done) begin
          if (vsel_q == VSEL_ACCEL) begin
            vel_q[comp_q] <= psu_sat32(66'(vel_q[comp_q]) + q_signed);
          end else begin
            vel_q[comp_q] <= psu_sat32(q_signed);
          end
        end
        if (go_vel_sq) begin
          acc_q <= '0;
        end
      end
      S_POS_ADD: pos_q[comp_q] <= psu_sat32(66'(pos_q[comp_q]) + step_signed);
      default: ;
    endcase
    if (fire_done) begin
      out_q.particle_out <= p_q;
      out_q.pos_x        <= pos_q[0];
      out_q.pos_y        <= pos_q[1];
      out_q.pos_z        <= pos_q[2];
      out_q.size_now     <= size_q;
      out_q.rgba_now     <= rgba_q;
      out_q.life_left    <= life_q;
    end
  end

  always_comb begin
    wr_entry.pos_x = pos_q[0];
    wr_entry.pos_y = pos_q[1];
    wr_entry.pos_z = pos_q[2];
    wr_entry.vel_x = vel_q[0];
    wr_entry.vel_y = vel_q[1];
    wr_entry.vel_z = vel_q[2];
    wr_entry.life  = life_q;
  end

  // One item at a time: the write-back of an item lands before the next read.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= mem_q[in_addr];
    end
    if (fire_done) begin
      mem_q[addr_q] <= wr_entry;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_wait_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AGE_WAIT || state_q == S_SQRT_WAIT || state_q == S_RS_WAIT)
      |-> (ar_rsp.busy || ar_rsp.done)) else $error("waiting on an idle arith unit");
  a_idle_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ar_rsp.busy) else $error("arith unit busy while idle");
  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    comp_q != 2'd3) else $error("component counter out of range");

endmodule

[rtl/psu_arith.sv]
// Bit-serial unsigned divider and integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module psu_arith (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psu_pkg::psu_ar_req_t  req_i,
  output psu_pkg::psu_ar_rsp_t  rsp_o
);
  import psu_pkg::*;

  logic                   busy_q, done_q;
  logic [AR_CNT_BITS-1:0] cnt_q;
  psu_arop_e              op_q;
  logic [31:0]            den_q;
  logic [34:0]            rem_q, rem_d;
  logic [63:0]            sh_q, sh_d;
  logic [31:0]            res_q, res_d;

  logic [32:0] div_r;
  logic [34:0] sq_r, sq_trial;
  logic        ge;

  // Division keeps a remainder below the divisor; the root keeps one at most twice the root.
  always_comb begin
    div_r    = {rem_q[31:0], sh_q[63]};
    sq_r     = {rem_q[32:0], sh_q[63:62]};
    sq_trial = {1'b0, res_q, 2'b01};
    ge       = 1'b0;
    rem_d    = rem_q;
    sh_d     = sh_q;
    unique case (op_q)
      AR_DIV: begin
        ge    = div_r >= {1'b0, den_q};
        rem_d = ge ? 35'(div_r - {1'b0, den_q}) : 35'(div_r);
        sh_d  = {sh_q[62:0], 1'b0};
      end
      AR_SQRT: begin
        ge    = sq_r >= sq_trial;
        rem_d = ge ? (sq_r - sq_trial) : sq_r;
        sh_d  = {sh_q[61:0], 2'b00};
      end
      default: ;
    endcase
    res_d = {res_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (&cnt_q);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      den_q <= req_i.den;
      res_q <= '0;
      if (req_i.op == AR_DIV) begin
        rem_q <= {3'd0, req_i.num[63:32]};
        sh_q  <= {req_i.num[31:0], 32'd0};
      end else begin
        rem_q <= '0;
        sh_q  <= req_i.num;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
      res_q <= res_d;
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("arith unit started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("arith done without a run");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0) else $error("arith step counter not parked");

endmodule
